### hdl/fdf_pkg.sv
// Package for the frame deframer: payload structs, status codes and header constants.
// Used by every module under hdl; depends on nothing else.
package fdf_pkg;

    localparam int BUFFER_BYTES = 8192;
    localparam int HEADER_BYTES = 6;

    // Largest payload length that fits in the receive buffer.
    localparam logic [16:0] LEN_LIMIT = 17'(BUFFER_BYTES - HEADER_BYTES);

    typedef enum logic [2:0] {
        ST_PROGRESS   = 3'd0,
        ST_DONE       = 3'd1,
        ST_LENGTH_ERR = 3'd2,
        ST_SEQ_ERR    = 3'd3,
        ST_HALTED     = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       signon_phase;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_last;
        status_t     status;
        logic [7:0]  frame_kind;
        logic [15:0] frame_sequence;
        logic [12:0] payload_length;
    } out_item_t;

endpackage

### hdl/fdf_in_stage.sv
// Input register of the frame deframer; holds one accepted byte until the parser takes it.
// Depends on fdf_pkg.
module fdf_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fdf_pkg::in_item_t in_data,
    input  logic              room,
    output logic              advance,
    output fdf_pkg::in_item_t item
);
    import fdf_pkg::*;

    logic     vld_reg;
    logic     vld_next;
    in_item_t data_reg;

    assign advance  = vld_reg & room;
    assign in_ready = ~vld_reg | room;
    assign item     = data_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

### hdl/fdf_parser.sv
// Header parser and sequence checker of the frame deframer; one byte per advance.
// Holds the frame state registers and forms one result per byte. Depends on fdf_pkg.
module fdf_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  fdf_pkg::in_item_t  item,
    output fdf_pkg::out_item_t result
);
    import fdf_pkg::*;

    localparam logic [2:0] HP_FIRST   = 3'd0;
    localparam logic [2:0] HP_KIND    = 3'd1;
    localparam logic [2:0] HP_SEQ_HI  = 3'd2;
    localparam logic [2:0] HP_SEQ_LO  = 3'd3;
    localparam logic [2:0] HP_LEN_HI  = 3'd4;
    localparam logic [2:0] HP_LEN_LO  = 3'd5;
    localparam logic [2:0] HP_PAYLOAD = 3'd6;

    logic [2:0]  hp_reg,     hp_next;
    logic [15:0] rem_reg,    rem_next;
    logic [7:0]  kind_reg,   kind_next;
    logic [15:0] seq_reg,    seq_next;
    logic [15:0] len_reg,    len_next;
    logic [15:0] exp_reg,    exp_next;
    logic        halted_reg, halted_next;

    logic [15:0] exp_inc;
    logic [15:0] rem_dec;
    logic [7:0]  byte_out;
    logic        valid_out;
    logic        last_out;
    status_t     st_out;

    always_comb
    begin
        hp_next     = hp_reg;
        rem_next    = rem_reg;
        kind_next   = kind_reg;
        seq_next    = seq_reg;
        len_next    = len_reg;
        exp_next    = exp_reg;
        halted_next = halted_reg;
        byte_out    = 8'd0;
        valid_out   = 1'b0;
        last_out    = 1'b0;
        st_out      = ST_PROGRESS;
        exp_inc     = exp_reg + 16'd1;
        rem_dec     = (rem_reg != 16'd0) ? rem_reg - 16'd1 : rem_reg;

        if (halted_reg)
        begin
            st_out = ST_HALTED;
        end
        else if (hp_reg == HP_PAYLOAD)
        begin
            rem_next  = rem_dec;
            valid_out = 1'b1;
            byte_out  = item.rx_byte;
            if (rem_dec == 16'd0)
            begin
                hp_next  = HP_FIRST;
                last_out = 1'b1;
                st_out   = ST_DONE;
            end
        end
        else
        begin
            case (hp_reg)
                HP_KIND:   kind_next = item.rx_byte;
                HP_SEQ_HI: seq_next  = {item.rx_byte, seq_reg[7:0]};
                HP_SEQ_LO: seq_next  = {seq_reg[15:8], item.rx_byte};
                HP_LEN_HI: len_next  = {item.rx_byte, len_reg[7:0]};
                HP_LEN_LO: len_next  = {len_reg[15:8], item.rx_byte};
                default:   kind_next = kind_reg;
            endcase

            if (hp_reg != HP_LEN_LO)
            begin
                hp_next = hp_reg + 3'd1;
            end
            else if ({1'b0, len_next} > LEN_LIMIT)
            begin
                halted_next = 1'b1;
                hp_next     = HP_FIRST;
                st_out      = ST_LENGTH_ERR;
            end
            else if (!item.signon_phase && (exp_inc != seq_next))
            begin
                exp_next    = exp_inc;
                halted_next = 1'b1;
                hp_next     = HP_FIRST;
                st_out      = ST_SEQ_ERR;
            end
            else
            begin
                exp_next = item.signon_phase ? seq_next : exp_inc;
                if (len_next == 16'd0)
                begin
                    hp_next  = HP_FIRST;
                    last_out = 1'b1;
                    st_out   = ST_DONE;
                end
                else
                begin
                    rem_next = len_next;
                    hp_next  = HP_PAYLOAD;
                end
            end
        end

        result.payload_byte   = byte_out;
        result.payload_valid  = valid_out;
        result.frame_last     = last_out;
        result.status         = st_out;
        result.frame_kind     = kind_next;
        result.frame_sequence = seq_next;
        result.payload_length = (len_next[15:13] != 3'd0) ? 13'h1FFF : len_next[12:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_reg     <= HP_FIRST;
            rem_reg    <= 16'd0;
            kind_reg   <= 8'd0;
            seq_reg    <= 16'd0;
            len_reg    <= 16'd0;
            exp_reg    <= 16'd0;
            halted_reg <= 1'b0;
        end
        else if (advance)
        begin
            hp_reg     <= hp_next;
            rem_reg    <= rem_next;
            kind_reg   <= kind_next;
            seq_reg    <= seq_next;
            len_reg    <= len_next;
            exp_reg    <= exp_next;
            halted_reg <= halted_next;
        end
    end

    // Once halted, the parser stays halted until reset.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("parser left the halted state without reset");

    a_halt_status: assert property (@(posedge clk) disable iff (!rst_n)
        advance && halted_reg |-> result.status == ST_HALTED)
        else $error("halted parser reported a status other than halted");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (result.status == ST_LENGTH_ERR || result.status == ST_SEQ_ERR)
        |=> halted_reg)
        else $error("header error did not halt the parser");

    a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.payload_valid |-> hp_reg == HP_PAYLOAD && !halted_reg)
        else $error("payload byte issued outside the payload phase");

endmodule

### hdl/fdf_out_queue.sv
// Two-entry result queue of the frame deframer; decouples the parser from output stalls.
// Depends on fdf_pkg.
module fdf_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fdf_pkg::out_item_t push_data,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output fdf_pkg::out_item_t out_data
);
    import fdf_pkg::*;

    out_item_t   mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;
    logic        pop;

    assign room      = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid & out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != 2'd2)
        else $error("result written into a full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with the count");

endmodule

### hdl/flap_frame_deframer_core.sv
// Frame deframer top level: input register, header parser and result queue.
// A byte passes the input register and then the result queue before its result is offered.
// Throughput: one byte per cycle while the result queue has room; a full queue stalls the input.
// Reset (rst_n, asynchronous, active low) clears the frame state and empties both stages.
// Depends on fdf_pkg, fdf_in_stage, fdf_parser and fdf_out_queue.
module flap_frame_deframer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fdf_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output fdf_pkg::out_item_t out_data
);
    import fdf_pkg::*;

    logic      room;
    logic      advance;
    in_item_t  item;
    out_item_t result;

    fdf_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .room     (room),
        .advance  (advance),
        .item     (item)
    );

    fdf_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    fdf_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_data (result),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Testbench for flap_frame_deframer_core: streams framed bytes with random gaps and stalls,
// predicts each result and compares every result transaction as it is accepted.
// Depends on fdf_pkg and the RTL under hdl.
module testbench;
    import fdf_pkg::*;

    localparam int MAX_LEN = BUFFER_BYTES - HEADER_BYTES;
    localparam logic [2:0] HDR_LAST = 3'd5;
    localparam logic [2:0] PAYLOAD_POS = 3'd6;
    localparam int RANDOM_BYTES = 740;
    localparam int PRESSURE_AT = 300;
    localparam int PRESSURE_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;

    in_item_t rx_stream[$];
    out_item_t deframed_q[$];
    int mismatch_count = 0;
    int results_taken = 0;
    int send_wait = 0;
    int send_calm = 0;
    int recv_wait = 0;
    int recv_calm = 0;

    logic [2:0] hdr_pos = '0;
    logic [12:0] bytes_left = '0;
    logic [7:0] kind_q = '0;
    logic [15:0] seq_q = '0;
    logic [15:0] len_q = '0;
    logic [15:0] seq_expect = '0;
    logic stopped = 1'b0;
    logic [15:0] gen_seq = '0;

    flap_frame_deframer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic out_item_t frame_result(logic [7:0] b, logic valid, logic last,
                                               status_t st);
        out_item_t r;
        r.payload_byte = b;
        r.payload_valid = valid;
        r.frame_last = last;
        r.status = st;
        r.frame_kind = kind_q;
        r.frame_sequence = seq_q;
        r.payload_length = (len_q > 16'h1FFF) ? 13'h1FFF : len_q[12:0];
        return r;
    endfunction

    function automatic out_item_t deframe_byte(in_item_t item);
        logic [7:0] b;
        b = item.rx_byte;
        if (stopped)
            return frame_result(8'h00, 1'b0, 1'b0, ST_HALTED);
        if (hdr_pos == PAYLOAD_POS)
        begin
            if (bytes_left != 0)
                bytes_left = bytes_left - 13'd1;
            if (bytes_left == 0)
            begin
                hdr_pos = '0;
                return frame_result(b, 1'b1, 1'b1, ST_DONE);
            end
            return frame_result(b, 1'b1, 1'b0, ST_PROGRESS);
        end
        case (hdr_pos)
            3'd1: kind_q = b;
            3'd2: seq_q[15:8] = b;
            3'd3: seq_q[7:0] = b;
            3'd4: len_q[15:8] = b;
            3'd5: len_q[7:0] = b;
            default: ;
        endcase
        if (hdr_pos < HDR_LAST)
        begin
            hdr_pos = hdr_pos + 3'd1;
            return frame_result(8'h00, 1'b0, 1'b0, ST_PROGRESS);
        end
        hdr_pos = '0;
        if (len_q > 16'(MAX_LEN))
        begin
            stopped = 1'b1;
            return frame_result(8'h00, 1'b0, 1'b0, ST_LENGTH_ERR);
        end
        if (item.signon_phase)
            seq_expect = seq_q;
        else
        begin
            seq_expect = seq_expect + 16'd1;
            if (seq_expect != seq_q)
            begin
                stopped = 1'b1;
                return frame_result(8'h00, 1'b0, 1'b0, ST_SEQ_ERR);
            end
        end
        if (len_q == 0)
            return frame_result(8'h00, 1'b0, 1'b1, ST_DONE);
        bytes_left = len_q[12:0];
        hdr_pos = PAYLOAD_POS;
        return frame_result(8'h00, 1'b0, 1'b0, ST_PROGRESS);
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 2);
    endfunction

    task automatic push_byte(logic [7:0] b, logic signon);
        in_item_t item;
        item.rx_byte = b;
        item.signon_phase = signon;
        rx_stream.push_back(item);
    endtask

    task automatic push_header(logic [7:0] lead, logic [7:0] kind, logic [15:0] seq,
                               logic [15:0] len, logic signon);
        push_byte(lead, 1'($urandom));
        push_byte(kind, 1'($urandom));
        push_byte(seq[15:8], 1'($urandom));
        push_byte(seq[7:0], 1'($urandom));
        push_byte(len[15:8], 1'($urandom));
        push_byte(len[7:0], signon);
    endtask

    task automatic push_payload(int count);
        for (int i = 0; i < count; i++)
            push_byte(8'($urandom), 1'($urandom));
    endtask

    task automatic push_good_frame(logic [15:0] len);
        logic signon;
        logic [15:0] seq;
        signon = ($urandom_range(0, 7) == 0);
        seq = signon ? 16'($urandom) : gen_seq + 16'd1;
        gen_seq = seq;
        push_header(8'($urandom), 8'($urandom), seq, len, signon);
        push_payload(len);
    endtask

    function automatic void check_result(out_item_t got);
        out_item_t want;
        if (deframed_q.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result %0d: no result was expected, got %h", results_taken, got);
            return;
        end
        want = deframed_q.pop_front();
        if (got.payload_byte !== want.payload_byte || got.payload_valid !== want.payload_valid
            || got.frame_last !== want.frame_last || got.status !== want.status
            || got.frame_kind !== want.frame_kind || got.frame_sequence !== want.frame_sequence
            || got.payload_length !== want.payload_length)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("result %0d: expected byte=%02h valid=%0b last=%0b status=%0d",
                         results_taken, want.payload_byte, want.payload_valid,
                         want.frame_last, want.status);
                $display("    kind=%02h seq=%04h len=%0d; got byte=%02h valid=%0b last=%0b",
                         want.frame_kind, want.frame_sequence, want.payload_length,
                         got.payload_byte, got.payload_valid, got.frame_last);
                $display("    status=%0d kind=%02h seq=%04h len=%0d", got.status,
                         got.frame_kind, got.frame_sequence, got.payload_length);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                deframed_q.push_back(deframe_byte(in_data));
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (rx_stream.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= rx_stream.pop_front();
                    send_wait = draw_wait(send_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                check_result(out_data);
                results_taken++;
                recv_wait = (results_taken == PRESSURE_AT) ? PRESSURE_CYCLES
                                                           : draw_wait(recv_calm);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        logic [15:0] len;

        // Signon frame at the top of the sequence space with an empty payload, then the
        // wrap to zero and payload bytes at both extremes.
        push_header(8'h00, 8'hFF, 16'hFFFF, 16'd0, 1'b1);
        push_header(8'hFF, 8'h00, 16'h0000, 16'd2, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_header(8'h5A, 8'hA5, 16'h0001, 16'd1, 1'b0);
        push_byte(8'hFF, 1'b1);
        gen_seq = 16'h0001;

        while (rx_stream.size() < RANDOM_BYTES)
        begin
            len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(13, 64))
                                              : 16'($urandom_range(0, 12));
            push_good_frame(len);
        end
        push_good_frame(16'($urandom_range(0, 12)));

        // The run ends on one error, since only a reset clears the halt.
        if ($urandom_range(0, 1) == 0)
        begin
            case ($urandom_range(0, 2))
                0: len = 16'(MAX_LEN + 1);
                1: len = 16'hFFFF;
                default: len = 16'($urandom_range(MAX_LEN + 2, 65534));
            endcase
            push_header(8'($urandom), 8'($urandom), 16'($urandom), len, 1'($urandom));
        end
        else
        begin
            push_header(8'($urandom), 8'($urandom),
                        gen_seq + 16'd1 + 16'($urandom_range(1, 65535)),
                        16'($urandom_range(0, 12)), 1'b0);
        end
        push_payload(12);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (rx_stream.size() != 0 || in_valid)
            @(posedge clk);
        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && deframed_q.size() == 0)
            $display("flap_frame_deframer_core: match");
        else
            $display("flap_frame_deframer_core: mismatch");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("flap_frame_deframer_core: mismatch");
        $finish;
    end

endmodule
